FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion forms for the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that must hold at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/bcpe_pkg.sv
// ----------------------------------------------------------------------------
// Bezier curve point evaluator package
// Widths, codes, types and helper functions shared by the evaluator files.
// ----------------------------------------------------------------------------
package bcpe_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = 5;
   localparam int COORD_W    = 32;
   localparam int U_W        = 17;
   localparam int W_W        = 33;
   localparam int WQ_W       = 31;
   localparam int DQ_W       = 32;
   localparam int ACC_W      = 64;
   localparam int RND_W      = ACC_W - 30;
   localparam int SAT_W      = RND_W + IDX_W + 1;

   localparam logic [U_W-1:0]   ONE_U       = U_W'(65536);
   localparam logic [W_W-1:0]   W_ONE       = {1'b1, {(W_W-1){1'b0}}};
   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   typedef struct packed {
      logic clear;
      logic enable;
   } acc_ctrl_type;

   function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
      logic [SAT_W-COORD_W:0] top;
      top = v[SAT_W-1:COORD_W-1];
      if ((&top) || !(|top)) begin
         sat_coord = v[COORD_W-1:0];
      end else if (v[SAT_W-1]) begin
         sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

endpackage

FILE: sv/bcpe_accum.sv
// ----------------------------------------------------------------------------
// Bezier evaluator accumulator
// Multiply-accumulate of weighted control points for the curve point and the
// derivative, with rounding to Q4.28, degree scaling and saturation.
// ----------------------------------------------------------------------------
module bcpe_accum (
   input  logic                                clock,
   input  bcpe_pkg::acc_ctrl_type              ctrl,
   input  logic [bcpe_pkg::WQ_W-1:0]           weight,
   input  logic signed [bcpe_pkg::DQ_W-1:0]    weight_diff,
   input  logic signed [bcpe_pkg::COORD_W-1:0] point_x,
   input  logic signed [bcpe_pkg::COORD_W-1:0] point_y,
   input  logic [bcpe_pkg::IDX_W-1:0]          degree,
   output logic [bcpe_pkg::COORD_W-1:0]        curve_x,
   output logic [bcpe_pkg::COORD_W-1:0]        curve_y,
   output logic [bcpe_pkg::COORD_W-1:0]        tangent_x,
   output logic [bcpe_pkg::COORD_W-1:0]        tangent_y
);

   logic signed [bcpe_pkg::ACC_W-1:0] sx_ff, sy_ff, dx_ff, dy_ff;
   logic signed [bcpe_pkg::ACC_W-1:0] px_w, py_w, px_d, py_d;
   logic signed [bcpe_pkg::ACC_W-1:0] rsx, rsy, rdx, rdy;
   logic signed [bcpe_pkg::RND_W-1:0] qsx, qsy, qdx, qdy;
   logic signed [bcpe_pkg::SAT_W-1:0] tdx, tdy;

   assign px_w = $signed({1'b0, weight}) * point_x;
   assign py_w = $signed({1'b0, weight}) * point_y;
   assign px_d = weight_diff * point_x;
   assign py_d = weight_diff * point_y;

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         sx_ff <= '0;
         sy_ff <= '0;
         dx_ff <= '0;
         dy_ff <= '0;
      end else if (ctrl.enable) begin
         sx_ff <= sx_ff + px_w;
         sy_ff <= sy_ff + py_w;
         dx_ff <= dx_ff + px_d;
         dy_ff <= dy_ff + py_d;
      end
   end

   assign rsx = sx_ff + bcpe_pkg::ACC_W'(64'sd536870912);
   assign rsy = sy_ff + bcpe_pkg::ACC_W'(64'sd536870912);
   assign rdx = dx_ff + bcpe_pkg::ACC_W'(64'sd536870912);
   assign rdy = dy_ff + bcpe_pkg::ACC_W'(64'sd536870912);
   assign qsx = rsx[bcpe_pkg::ACC_W-1:30];
   assign qsy = rsy[bcpe_pkg::ACC_W-1:30];
   assign qdx = rdx[bcpe_pkg::ACC_W-1:30];
   assign qdy = rdy[bcpe_pkg::ACC_W-1:30];
   assign tdx = qdx * $signed({1'b0, degree});
   assign tdy = qdy * $signed({1'b0, degree});

   assign curve_x   = bcpe_pkg::sat_coord(bcpe_pkg::SAT_W'(qsx));
   assign curve_y   = bcpe_pkg::sat_coord(bcpe_pkg::SAT_W'(qsy));
   assign tangent_x = bcpe_pkg::sat_coord(tdx);
   assign tangent_y = bcpe_pkg::sat_coord(tdy);

endmodule

FILE: sv/bezier_curve_point_evaluator.sv
// ----------------------------------------------------------------------------
// Bezier curve point evaluator
// Holds 2-D control points and returns the curve point and its derivative.
// ----------------------------------------------------------------------------
// A transfer on the request side happens at a rising edge with start high and
// busy low. A load request writes one control point in that cycle and leaves
// busy low, so requests may follow every cycle. An evaluate request raises
// busy and walks the Bernstein weight table, held in a two-port memory: a
// read, a multiply-add and a write-back per entry, degree by degree, with the
// final degree also feeding the multiply-accumulate of the control points.
// The walk runs over degrees 1 to n, n being the clamped point count minus
// one; busy stays high until the walk and the accumulation have drained, and
// the result transfer is shown on the rsp_ ports in the cycle busy falls,
// marked by rsp_valid for exactly one cycle. The receiver cannot stall; a new
// request may be taken while a result is being shown.
// The csr_ port writes point_count at any edge with csr_write_enable high and
// reset low. Reset returns point_count to four and aborts any evaluation.
// Control points are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bezier_curve_point_evaluator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic [3:0]                          req_point_index,
   input  logic signed [bcpe_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [bcpe_pkg::COORD_W-1:0] req_point_y,
   input  logic [bcpe_pkg::U_W-1:0]            req_param_u,
   output logic                                rsp_valid,
   output logic signed [bcpe_pkg::COORD_W-1:0] rsp_curve_x,
   output logic signed [bcpe_pkg::COORD_W-1:0] rsp_curve_y,
   output logic signed [bcpe_pkg::COORD_W-1:0] rsp_tangent_x,
   output logic signed [bcpe_pkg::COORD_W-1:0] rsp_tangent_y,
   input  logic                                csr_write_enable,
   input  logic [bcpe_pkg::CNT_W-1:0]          csr_write_data
);

   bcpe_pkg::state_type state_ff, state_in;
   logic [bcpe_pkg::CNT_W-1:0] point_count_ff;
   logic [bcpe_pkg::IDX_W-1:0] n_ff, n_in, k1_ff, k1_in, j1_ff, j1_in;
   logic [bcpe_pkg::IDX_W-1:0] k2_ff, j2_ff;
   logic                       v2_ff, v2_in, v3_ff, v3_in, rsp_valid_ff, rsp_valid_in;
   logic [bcpe_pkg::U_W-1:0]   u_ff;
   logic                       load_fire, eval_fire, issue, last_issue;

   logic [bcpe_pkg::COORD_W-1:0] xmem [bcpe_pkg::MAX_POINTS];
   logic [bcpe_pkg::COORD_W-1:0] ymem [bcpe_pkg::MAX_POINTS];
   logic [bcpe_pkg::W_W-1:0]     wmem [bcpe_pkg::MAX_POINTS];
   logic [bcpe_pkg::COORD_W-1:0] px_rd_ff, py_rd_ff, px3_ff, py3_ff;
   logic [bcpe_pkg::W_W-1:0]     w_rd_ff, cur_ff, cur, prev, w_new;
   logic signed [bcpe_pkg::W_W:0]   diff;
   logic signed [bcpe_pkg::W_W+18:0] prod, wsum;
   logic [bcpe_pkg::W_W:0]       rq_new, rq_cur, rq_prev;
   logic [bcpe_pkg::WQ_W-1:0]    wq_new, wq3_ff;
   logic signed [bcpe_pkg::DQ_W-1:0] dq, dq3_ff;

   bcpe_pkg::acc_ctrl_type       acc_ctrl;
   logic [bcpe_pkg::COORD_W-1:0] cx, cy, tx, ty;

   assign busy      = (state_ff != bcpe_pkg::ST_IDLE);
   assign load_fire = start && !busy && (req_command == bcpe_pkg::CMD_LOAD)
                      && (32'(req_point_index) < bcpe_pkg::MAX_POINTS);
   assign eval_fire = start && !busy && (req_command == bcpe_pkg::CMD_EVAL);
   assign issue      = (state_ff == bcpe_pkg::ST_RUN);
   assign last_issue = issue && (j1_ff == '0) && (k1_ff == n_ff);

   always_comb begin
      if (point_count_ff < bcpe_pkg::CNT_W'(2)) begin
         n_in = bcpe_pkg::IDX_W'(1);
      end else if ({1'b0, point_count_ff} > (bcpe_pkg::CNT_W+1)'(bcpe_pkg::MAX_POINTS)) begin
         n_in = bcpe_pkg::IDX_W'(bcpe_pkg::MAX_POINTS - 1);
      end else begin
         n_in = bcpe_pkg::IDX_W'(point_count_ff - 1'b1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      k1_in        = k1_ff;
      j1_in        = j1_ff;
      rsp_valid_in = 1'b0;
      v2_in        = issue;
      v3_in        = v2_ff && (k2_ff == n_ff);
      case (state_ff)
         bcpe_pkg::ST_IDLE: begin
            if (eval_fire) begin
               state_in = bcpe_pkg::ST_RUN;
               k1_in    = bcpe_pkg::IDX_W'(1);
               j1_in    = bcpe_pkg::IDX_W'(1);
            end
         end
         bcpe_pkg::ST_RUN: begin
            if (last_issue) begin
               state_in = bcpe_pkg::ST_DRAIN;
            end else if (j1_ff == '0) begin
               k1_in = k1_ff + 1'b1;
               j1_in = k1_ff + 1'b1;
            end else begin
               j1_in = j1_ff - 1'b1;
            end
         end
         bcpe_pkg::ST_DRAIN: begin
            if (!v2_ff && !v3_ff) begin
               state_in     = bcpe_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = bcpe_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bcpe_pkg::ST_IDLE;
         point_count_ff <= bcpe_pkg::COUNT_RESET;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            point_count_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      k1_ff <= k1_in;
      j1_ff <= j1_in;
      k2_ff <= k1_ff;
      j2_ff <= j1_ff;
      if (eval_fire) begin
         n_ff <= n_in;
         u_ff <= (req_param_u > bcpe_pkg::ONE_U) ? bcpe_pkg::ONE_U : req_param_u;
      end
      if (rsp_valid_in) begin
         rsp_curve_x   <= cx;
         rsp_curve_y   <= cy;
         rsp_tangent_x <= tx;
         rsp_tangent_y <= ty;
      end
   end

   always_ff @(posedge clock) begin
      if (load_fire) begin
         xmem[bcpe_pkg::IDX_W'(req_point_index)] <= req_point_x;
         ymem[bcpe_pkg::IDX_W'(req_point_index)] <= req_point_y;
      end
      px_rd_ff <= xmem[j1_ff];
      py_rd_ff <= ymem[j1_ff];
   end

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         wmem[j2_ff] <= w_new;
      end
      w_rd_ff <= wmem[j1_ff - 1'b1];
   end

   always_comb begin
      cur = (j2_ff == k2_ff) ? '0 : cur_ff;
      if (j2_ff == '0) begin
         prev = '0;
      end else if ((k2_ff == bcpe_pkg::IDX_W'(1)) && (j2_ff == bcpe_pkg::IDX_W'(1))) begin
         prev = bcpe_pkg::W_ONE;
      end else begin
         prev = w_rd_ff;
      end
      diff    = $signed({1'b0, prev}) - $signed({1'b0, cur});
      prod    = $signed({1'b0, u_ff}) * diff;
      wsum    = $signed({3'b000, cur, 16'h0000}) + prod + (bcpe_pkg::W_W+19)'(32768);
      w_new   = wsum[bcpe_pkg::W_W+15:16];
      rq_new  = {1'b0, w_new} + (bcpe_pkg::W_W+1)'(2);
      rq_cur  = {1'b0, cur} + (bcpe_pkg::W_W+1)'(2);
      rq_prev = {1'b0, prev} + (bcpe_pkg::W_W+1)'(2);
      wq_new  = rq_new[bcpe_pkg::WQ_W+1:2];
      dq      = $signed({1'b0, rq_prev[bcpe_pkg::WQ_W+1:2]})
                - $signed({1'b0, rq_cur[bcpe_pkg::WQ_W+1:2]});
   end

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         cur_ff <= prev;
      end
      wq3_ff <= wq_new;
      dq3_ff <= dq;
      px3_ff <= px_rd_ff;
      py3_ff <= py_rd_ff;
   end

   assign acc_ctrl.clear  = eval_fire;
   assign acc_ctrl.enable = v3_ff;

   bcpe_accum u_accum (
      .clock       (clock),
      .ctrl        (acc_ctrl),
      .weight      (wq3_ff),
      .weight_diff (dq3_ff),
      .point_x     ($signed(px3_ff)),
      .point_y     ($signed(py3_ff)),
      .degree      (n_ff),
      .curve_x     (cx),
      .curve_y     (cy),
      .tangent_x   (tx),
      .tangent_y   (ty)
   );

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_CLK(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "result strobe longer than one cycle")
   `ASSERT_CLK(a_eval_busy, clock, reset, eval_fire |=> busy, "evaluate transfer did not raise busy")
   `ASSERT_CLK(a_acc_in_eval, clock, reset, v3_ff |-> (state_ff == bcpe_pkg::ST_RUN || state_ff == bcpe_pkg::ST_DRAIN), "accumulate outside an evaluation")
   `ASSERT_CLK(a_rsp_after_drain, clock, reset, rsp_valid |-> $past(state_ff == bcpe_pkg::ST_DRAIN), "result without a finished evaluation")

endmodule
